>>> src/truss_element_geometry_defines.svh
// ============================================================================
// Truss element geometry assertion macros
// Shared concurrent assertion forms used by the RTL of the block.
// ============================================================================
`ifndef TRUSS_ELEMENT_GEOMETRY_DEFINES_SVH
`define TRUSS_ELEMENT_GEOMETRY_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define TEG_ASSERT_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define TEG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/teg_pkg.sv
// ============================================================================
// Truss element geometry package
// Types shared between the front stage, the queue and the back end.
// ============================================================================
`default_nettype none

package teg_pkg;

    // One classified element waiting in the queue.
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic [65:0]        sumsq;
        logic [63:0]        ae;
        logic               zero;
    } teg_item_t;

    // One finished result.
    typedef struct packed {
        logic [33:0]        bar_length;
        logic [47:0]        axial_stiffness;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] side_x;
        logic signed [31:0] side_y;
        logic signed [31:0] side_z;
        logic signed [31:0] third_x;
        logic signed [31:0] third_y;
        logic signed [31:0] third_z;
        logic               zero_length;
    } teg_result_t;

endpackage

`default_nettype wire

>>> src/teg_front.sv
// ============================================================================
// Truss element geometry front stage
// Forms the node difference, the squared length and area times modulus,
// and flags zero-length elements, in two register stages.
// ============================================================================
`default_nettype none

module teg_front #(
    parameter int DEPTH = 4
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic signed [31:0]        start_x,
    input  wire logic signed [31:0]        start_y,
    input  wire logic signed [31:0]        start_z,
    input  wire logic signed [31:0]        end_x,
    input  wire logic signed [31:0]        end_y,
    input  wire logic signed [31:0]        end_z,
    input  wire logic [31:0]               area,
    input  wire logic [31:0]               young_modulus,
    input  wire logic [$clog2(DEPTH+1)-1:0] level,
    output logic                           wr_en,
    output teg_pkg::teg_item_t             wr_item
);

    localparam int LW = $clog2(DEPTH + 3);

    logic               s1_valid_reg;
    logic signed [32:0] s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic [31:0]        s1_area_reg;
    logic               s2_valid_reg;
    logic signed [32:0] s2_dx_reg, s2_dy_reg, s2_dz_reg;
    logic [64:0]        s2_sqx_reg, s2_sqy_reg, s2_sqz_reg;
    logic [63:0]        s2_ae_reg;
    logic [32:0]        mag_x, mag_y, mag_z;
    logic               accept;

    // Room is counted over the queue and both stages in flight.
    assign full   = (LW'(level) + LW'(s1_valid_reg) + LW'(s2_valid_reg)) >= LW'(DEPTH);
    assign accept = push && !full;

    // Stage one: exact differences.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_dx_reg   <= {end_x[31], end_x} - {start_x[31], start_x};
            s1_dy_reg   <= {end_y[31], end_y} - {start_y[31], start_y};
            s1_dz_reg   <= {end_z[31], end_z} - {start_z[31], start_z};
            s1_area_reg <= area;
        end
    end

    // Magnitudes of the differences; the most negative value maps to 2^32.
    assign mag_x = s1_dx_reg[32] ? 33'(-s1_dx_reg) : s1_dx_reg;
    assign mag_y = s1_dy_reg[32] ? 33'(-s1_dy_reg) : s1_dy_reg;
    assign mag_z = s1_dz_reg[32] ? 33'(-s1_dz_reg) : s1_dz_reg;

    // Stage two: squares and area times modulus.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_dx_reg  <= s1_dx_reg;
            s2_dy_reg  <= s1_dy_reg;
            s2_dz_reg  <= s1_dz_reg;
            s2_sqx_reg <= 65'(mag_x * mag_x);
            s2_sqy_reg <= 65'(mag_y * mag_y);
            s2_sqz_reg <= 65'(mag_z * mag_z);
            s2_ae_reg  <= s1_area_reg * young_modulus;
        end
    end

    // Sum of squares and classification into the queue.
    assign wr_en            = s2_valid_reg;
    assign wr_item.dx       = s2_dx_reg;
    assign wr_item.dy       = s2_dy_reg;
    assign wr_item.dz       = s2_dz_reg;
    assign wr_item.sumsq    = 66'(s2_sqx_reg) + 66'(s2_sqy_reg) + 66'(s2_sqz_reg);
    assign wr_item.ae       = s2_ae_reg;
    assign wr_item.zero     = (s2_dx_reg == '0) && (s2_dy_reg == '0) && (s2_dz_reg == '0);

endmodule

`default_nettype wire

>>> src/teg_fifo.sv
// ============================================================================
// Truss element geometry item queue
// Short queue that decouples the front stage from the back end.
// ============================================================================
`default_nettype none

`include "truss_element_geometry_defines.svh"

module teg_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire teg_pkg::teg_item_t         wr_item,
    input  wire logic                       rd_en,
    output teg_pkg::teg_item_t              rd_item,
    output logic                            rd_empty,
    output logic [$clog2(DEPTH+1)-1:0]      level
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    teg_pkg::teg_item_t mem [DEPTH];
    logic [AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]      count_reg;

    // Storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign rd_item  = mem[rd_ptr_reg];
    assign rd_empty = (count_reg == '0);
    assign level    = count_reg;

    `TEG_ASSERT_HOLDS(a_level_bound, count_reg <= CW'(DEPTH), "queue level above depth")
    `TEG_ASSERT_HOLDS(a_no_overrun, !wr_en || rd_en || count_reg != CW'(DEPTH), "write to full queue")
    `TEG_ASSERT_HOLDS(a_no_underrun, !rd_en || count_reg != '0, "read from empty queue")

endmodule

`default_nettype wire

>>> src/teg_back.sv
// ============================================================================
// Truss element geometry back end
// Square root, four division lanes, local axes and the result register.
// ============================================================================
`default_nettype none

`include "truss_element_geometry_defines.svh"

module teg_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire teg_pkg::teg_item_t   rd_item,
    input  wire logic                 rd_empty,
    output logic                      rd_en,
    output teg_pkg::teg_result_t      result,
    output logic                      empty,
    input  wire logic                 pop
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SQRT = 6'b000010,
        S_DIV  = 6'b000100,
        S_AX   = 6'b001000,
        S_MUL  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    localparam int LANES = 4;

    state_t             state_reg, state_next;
    teg_pkg::teg_item_t item_reg;
    logic [65:0]        rad_reg;
    logic [32:0]        root_reg;
    logic [35:0]        rem_reg;
    logic [5:0]         cnt_reg;
    logic [32:0]        len_reg;
    logic [63:0]        dvd_reg  [LANES];
    logic [32:0]        drem_reg [LANES];
    logic [63:0]        dvd_next [LANES];
    logic [32:0]        drem_next[LANES];
    logic signed [31:0] e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    logic [47:0]        stiff_reg;
    logic signed [63:0] prod_reg [6];
    teg_pkg::teg_result_t res_reg;
    logic               out_valid_reg;
    logic [35:0]        rem_s, trial;
    logic               sq_ge;
    logic [32:0]        root_next;
    logic [35:0]        rem_next;
    logic [32:0]        mag_x, mag_y, mag_z;
    logic signed [31:0] e1x, e1y, e1z;
    logic               load_out;
    teg_pkg::teg_result_t res_next;

    // Q2.60 to Q1.30 rounding with ties upward, clamped to plus or minus one.
    function automatic logic signed [31:0] round_q30(input logic signed [63:0] v);
        logic signed [63:0] t;
        logic signed [63:0] r;
        t = v + 64'sd536870912;
        r = t >>> 30;
        if (r > 64'sd1073741824)
        begin
            r = 64'sd1073741824;
        end
        if (r < -64'sd1073741824)
        begin
            r = -64'sd1073741824;
        end
        return r[31:0];
    endfunction

    // Signed Q1.30 component from a quotient magnitude.
    function automatic logic signed [31:0] signed_q(input logic neg, input logic [63:0] q);
        logic signed [31:0] m;
        m = {1'b0, q[30:0]};
        return neg ? -m : m;
    endfunction

    // One bit of the square root per cycle.
    assign rem_s     = {rem_reg[33:0], rad_reg[65:64]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign sq_ge     = rem_s >= trial;
    assign rem_next  = sq_ge ? rem_s - trial : rem_s;
    assign root_next = {root_reg[31:0], sq_ge};

    // One quotient bit per lane per cycle: stiffness and three direction lanes.
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic [33:0] r;
        logic        ge;
        assign r            = {drem_reg[g], dvd_reg[g][63]};
        assign ge           = r >= {1'b0, len_reg};
        assign drem_next[g] = ge ? 33'(r - {1'b0, len_reg}) : r[32:0];
        assign dvd_next[g]  = {dvd_reg[g][62:0], ge};
    end

    assign mag_x = item_reg.dx[32] ? 33'(-item_reg.dx) : item_reg.dx;
    assign mag_y = item_reg.dy[32] ? 33'(-item_reg.dy) : item_reg.dy;
    assign mag_z = item_reg.dz[32] ? 33'(-item_reg.dz) : item_reg.dz;

    assign e1x = signed_q(item_reg.dx[32], dvd_reg[1]);
    assign e1y = signed_q(item_reg.dy[32], dvd_reg[2]);
    assign e1z = signed_q(item_reg.dz[32], dvd_reg[3]);

    // Sequencer.
    assign rd_en    = (state_reg == S_IDLE) && !rd_empty;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || pop);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!rd_empty)
                begin
                    state_next = rd_item.zero ? S_DONE : S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_AX;
                end
            end
            S_AX:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                item_reg <= rd_item;
                rad_reg  <= rd_item.sumsq;
                root_reg <= '0;
                rem_reg  <= '0;
                cnt_reg  <= 6'd32;
            end
            S_SQRT:
            begin
                rad_reg  <= {rad_reg[63:0], 2'b00};
                root_reg <= root_next;
                rem_reg  <= rem_next;
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    len_reg     <= root_next;
                    cnt_reg     <= 6'd63;
                    dvd_reg[0]  <= item_reg.ae;
                    dvd_reg[1]  <= {1'b0, mag_x, 30'b0};
                    dvd_reg[2]  <= {1'b0, mag_y, 30'b0};
                    dvd_reg[3]  <= {1'b0, mag_z, 30'b0};
                    for (int i = 0; i < LANES; i++)
                    begin
                        drem_reg[i] <= '0;
                    end
                end
            end
            S_DIV:
            begin
                cnt_reg <= cnt_reg - 1'b1;
                for (int i = 0; i < LANES; i++)
                begin
                    dvd_reg[i]  <= dvd_next[i];
                    drem_reg[i] <= drem_next[i];
                end
            end
            S_AX:
            begin
                e1x_reg   <= e1x;
                e1y_reg   <= e1y;
                e1z_reg   <= e1z;
                stiff_reg <= (dvd_reg[0][63:48] != '0) ? '1 : dvd_reg[0][47:0];
                // Helper axis is x when the quantized e1.x is zero, else y.
                if (e1x == '0)
                begin
                    e2x_reg <= '0;
                    e2y_reg <= e1z;
                    e2z_reg <= -e1y;
                end
                else
                begin
                    e2x_reg <= -e1z;
                    e2y_reg <= '0;
                    e2z_reg <= e1x;
                end
            end
            S_MUL:
            begin
                prod_reg[0] <= e1y_reg * e2z_reg;
                prod_reg[1] <= e1z_reg * e2y_reg;
                prod_reg[2] <= e1z_reg * e2x_reg;
                prod_reg[3] <= e1x_reg * e2z_reg;
                prod_reg[4] <= e1x_reg * e2y_reg;
                prod_reg[5] <= e1y_reg * e2x_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Result assembly; a zero-length element gives only the flag.
    always_comb
    begin
        res_next = '0;
        if (item_reg.zero)
        begin
            res_next.zero_length = 1'b1;
        end
        else
        begin
            res_next.bar_length      = {1'b0, len_reg};
            res_next.axial_stiffness = stiff_reg;
            res_next.dir_x           = e1x_reg;
            res_next.dir_y           = e1y_reg;
            res_next.dir_z           = e1z_reg;
            res_next.side_x          = e2x_reg;
            res_next.side_y          = e2y_reg;
            res_next.side_z          = e2z_reg;
            res_next.third_x         = round_q30(prod_reg[0] - prod_reg[1]);
            res_next.third_y         = round_q30(prod_reg[2] - prod_reg[3]);
            res_next.third_z         = round_q30(prod_reg[4] - prod_reg[5]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;
    assign empty  = !out_valid_reg;

    `TEG_ASSERT_HOLDS(a_zero_clean, !(out_valid_reg && res_reg.zero_length) || (res_reg.bar_length == '0 && res_reg.axial_stiffness == '0), "zero-length result not cleared")
    `TEG_ASSERT_NEXT(a_pop_starts, rd_en, state_reg == S_SQRT || state_reg == S_DONE, "item taken but no work started")
    `TEG_ASSERT_HOLDS(a_len_nonzero, state_reg != S_AX || len_reg != '0, "division by zero length")

endmodule

`default_nettype wire

>>> src/truss_element_geometry.sv
// ----------------------------------------------------------------------------
// Usage: a bar element goes in through a queue-style port (push/full) with its
// start point, end point and area; one result comes out per element through a
// queue-style port (empty/pop) with length, axial stiffness, three local axes
// and the zero-length flag. Young's modulus is to be written on the cfg
// channel (cfg_valid/cfg_ready/cfg_data) only while the block is idle; the
// block does not enforce this, and cfg_ready is high. Behind the front stages
// and the queue, the back end takes the request, runs a bit-serial square
// root, the four division lanes, the axes and the products, and hands over
// to the result register; a zero-length element goes from taking the request
// straight to the hand over. The back end takes the next element only after
// the hand over. The front stage and the item queue keep accepting while the
// back end works, so up to DEPTH elements wait behind the one in the back
// end. Reset clears the queue, the sequencer and the result valid flag; the
// modulus returns to 1.0. When the receiver does not pop, the finished result
// holds, the back end stops at its last step and the queue fills until full
// rises.
// ----------------------------------------------------------------------------
// ============================================================================
// Truss element geometry
// Length, axial stiffness and local axes of a 3D bar element.
// ============================================================================
`default_nettype none

module truss_element_geometry #(
    parameter int DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [31:0] start_x,
    input  wire logic signed [31:0] start_y,
    input  wire logic signed [31:0] start_z,
    input  wire logic signed [31:0] end_x,
    input  wire logic signed [31:0] end_y,
    input  wire logic signed [31:0] end_z,
    input  wire logic [31:0]        area,
    output logic                    empty,
    input  wire logic               pop,
    output logic [33:0]             bar_length,
    output logic [47:0]             axial_stiffness,
    output logic signed [31:0]      dir_x,
    output logic signed [31:0]      dir_y,
    output logic signed [31:0]      dir_z,
    output logic signed [31:0]      side_x,
    output logic signed [31:0]      side_y,
    output logic signed [31:0]      side_z,
    output logic signed [31:0]      third_x,
    output logic signed [31:0]      third_y,
    output logic signed [31:0]      third_z,
    output logic                    zero_length,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [31:0]        cfg_data
);

    logic [31:0]                young_modulus_reg;
    logic [$clog2(DEPTH+1)-1:0] level;
    logic                       wr_en, rd_en, rd_empty;
    teg_pkg::teg_item_t         wr_item, rd_item;
    teg_pkg::teg_result_t       result;

    // Modulus register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            young_modulus_reg <= 32'h0001_0000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            young_modulus_reg <= cfg_data;
        end
    end

    teg_front #(.DEPTH(DEPTH)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .start_x       (start_x),
        .start_y       (start_y),
        .start_z       (start_z),
        .end_x         (end_x),
        .end_y         (end_y),
        .end_z         (end_z),
        .area          (area),
        .young_modulus (young_modulus_reg),
        .level         (level),
        .wr_en         (wr_en),
        .wr_item       (wr_item)
    );

    teg_fifo #(.DEPTH(DEPTH)) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_item  (wr_item),
        .rd_en    (rd_en),
        .rd_item  (rd_item),
        .rd_empty (rd_empty),
        .level    (level)
    );

    teg_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_item  (rd_item),
        .rd_empty (rd_empty),
        .rd_en    (rd_en),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

    // Result fields onto their ports.
    assign bar_length      = result.bar_length;
    assign axial_stiffness = result.axial_stiffness;
    assign dir_x           = result.dir_x;
    assign dir_y           = result.dir_y;
    assign dir_z           = result.dir_z;
    assign side_x          = result.side_x;
    assign side_y          = result.side_y;
    assign side_z          = result.side_z;
    assign third_x         = result.third_x;
    assign third_y         = result.third_y;
    assign third_z         = result.third_z;
    assign zero_length     = result.zero_length;

endmodule

`default_nettype wire

>>> tb/truss_element_geometry_tb.sv
// ============================================================================
// Truss element geometry testbench
// Streams bar elements through the queue-style ports under random bursts and
// receiver stalls. Each element's length, stiffness and local axes are
// predicted in the testbench and compared field by field with the results.
// ============================================================================
`default_nettype none

module truss_element_geometry_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [47:0] STIFF_MAX   = 48'hFFFF_FFFF_FFFF;
    localparam longint      ONE_Q30     = 64'sd1073741824;
    localparam int          DRAIN_WAIT  = 400;

    typedef struct {
        logic signed [31:0] sx, sy, sz, ex, ey, ez;
        logic [31:0]        area;
    } bar_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty, cfg_ready, zero_length;
    logic signed [31:0] start_x = '0, start_y = '0, start_z = '0;
    logic signed [31:0] end_x = '0, end_y = '0, end_z = '0;
    logic [31:0] area = '0;
    logic [33:0] bar_length;
    logic [47:0] axial_stiffness;
    logic signed [31:0] dir_x, dir_y, dir_z, side_x, side_y, side_z;
    logic signed [31:0] third_x, third_y, third_z;
    logic cfg_valid = 1'b0;
    logic [31:0] cfg_data = '0;

    bar_t                 bar_queue[$];
    teg_pkg::teg_result_t expected_geometry[$];
    logic [31:0]          modulus;
    int                   fail_count = 0;
    bit                   feeding = 1'b0;
    int                   burst_left = 0;
    int                   gap_left = 0;
    int                   stall_phase = 0;

    truss_element_geometry DUT (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    // Floor square root of a 66-bit sum of squares.
    function automatic logic [33:0] floor_sqrt(logic [65:0] v);
        logic [33:0] root;
        logic [67:0] rem, trial;
        root = '0;
        rem = '0;
        for (int i = 32; i >= 0; i--)
        begin
            rem = (rem << 2) | 68'(v[2*i +: 2]);
            trial = (68'(root) << 2) | 68'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 34'd1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    // Component of the unit direction, truncated toward zero.
    function automatic longint unit_part(longint d, logic [33:0] len);
        logic [63:0] mag, q;
        mag = (d < 0) ? 64'(-d) : 64'(d);
        q = (mag << 30) / 64'(len);
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Q2.60 to Q1.30 with ties rounded upward, clamped to plus or minus one.
    function automatic longint round_axis(longint v);
        longint r;
        r = (v + (64'sd1 <<< 29)) >>> 30;
        if (r > ONE_Q30) r = ONE_Q30;
        if (r < -ONE_Q30) r = -ONE_Q30;
        return r;
    endfunction

    function automatic teg_pkg::teg_result_t bar_geometry(bar_t b);
        teg_pkg::teg_result_t res;
        longint d[3], e1[3], e2[3], e3[3];
        logic [65:0] sumsq;
        logic [33:0] len;
        logic [63:0] ae, stiff;
        res = '0;
        d[0] = longint'(b.ex) - longint'(b.sx);
        d[1] = longint'(b.ey) - longint'(b.sy);
        d[2] = longint'(b.ez) - longint'(b.sz);
        sumsq = '0;
        for (int i = 0; i < 3; i++)
            sumsq += 66'(d[i] < 0 ? -d[i] : d[i]) * 66'(d[i] < 0 ? -d[i] : d[i]);
        len = floor_sqrt(sumsq);
        if (len == 0)
        begin
            res.zero_length = 1'b1;
            return res;
        end
        ae = 64'(b.area) * 64'(modulus);
        stiff = ae / 64'(len);
        if (stiff > 64'(STIFF_MAX))
            stiff = 64'(STIFF_MAX);
        for (int i = 0; i < 3; i++)
            e1[i] = unit_part(d[i], len);
        if (e1[0] == 0)
        begin
            e2[0] = 0; e2[1] = e1[2]; e2[2] = -e1[1];
        end
        else
        begin
            e2[0] = -e1[2]; e2[1] = 0; e2[2] = e1[0];
        end
        e3[0] = round_axis(e1[1] * e2[2] - e1[2] * e2[1]);
        e3[1] = round_axis(e1[2] * e2[0] - e1[0] * e2[2]);
        e3[2] = round_axis(e1[0] * e2[1] - e1[1] * e2[0]);
        res.bar_length = len;
        res.axial_stiffness = stiff[47:0];
        res.dir_x = 32'(e1[0]); res.dir_y = 32'(e1[1]); res.dir_z = 32'(e1[2]);
        res.side_x = 32'(e2[0]); res.side_y = 32'(e2[1]); res.side_z = 32'(e2[2]);
        res.third_x = 32'(e3[0]); res.third_y = 32'(e3[1]); res.third_z = 32'(e3[2]);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Request driver: bursts of pushes separated by random gaps.
    always @(posedge clk)
    begin
        if (push && !full)
        begin
            expected_geometry.push_back(bar_geometry(bar_queue.pop_front()));
        end
        if (!(push && full))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                push <= 1'b0;
            end
            else if (feeding && bar_queue.size() > 0)
            begin
                bar_t b;
                b = bar_queue[0];
                push <= 1'b1;
                start_x <= b.sx; start_y <= b.sy; start_z <= b.sz;
                end_x <= b.ex; end_y <= b.ey; end_z <= b.ez;
                area <= b.area;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                push <= 1'b0;
        end
    end

    // Result monitor with a receiver stall pattern.
    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            if (expected_geometry.size() == 0)
            begin
                report_mismatch("result with no element pending", 64'd1, 64'd0);
            end
            else
            begin
                teg_pkg::teg_result_t w;
                w = expected_geometry.pop_front();
                if (bar_length !== w.bar_length)
                    report_mismatch("bar_length", 64'(bar_length), 64'(w.bar_length));
                if (axial_stiffness !== w.axial_stiffness)
                    report_mismatch("axial_stiffness", 64'(axial_stiffness),
                                    64'(w.axial_stiffness));
                if (dir_x !== w.dir_x) report_mismatch("dir_x", 64'(dir_x), 64'(w.dir_x));
                if (dir_y !== w.dir_y) report_mismatch("dir_y", 64'(dir_y), 64'(w.dir_y));
                if (dir_z !== w.dir_z) report_mismatch("dir_z", 64'(dir_z), 64'(w.dir_z));
                if (side_x !== w.side_x) report_mismatch("side_x", 64'(side_x), 64'(w.side_x));
                if (side_y !== w.side_y) report_mismatch("side_y", 64'(side_y), 64'(w.side_y));
                if (side_z !== w.side_z) report_mismatch("side_z", 64'(side_z), 64'(w.side_z));
                if (third_x !== w.third_x)
                    report_mismatch("third_x", 64'(third_x), 64'(w.third_x));
                if (third_y !== w.third_y)
                    report_mismatch("third_y", 64'(third_y), 64'(w.third_y));
                if (third_z !== w.third_z)
                    report_mismatch("third_z", 64'(third_z), 64'(w.third_z));
                if (zero_length !== w.zero_length)
                    report_mismatch("zero_length", 64'(zero_length), 64'(w.zero_length));
            end
        end
        stall_phase <= (stall_phase + 1) % 600;
        if (stall_phase < 200)
            pop <= 1'b1;
        else if (stall_phase < 300)
            pop <= ($urandom_range(0, 7) != 0);
        else if (stall_phase < 350)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(0, 2) != 0);
    end

    task automatic add_bar(logic [31:0] sx, sy, sz, ex, ey, ez, a);
        bar_t b;
        b.sx = sx; b.sy = sy; b.sz = sz; b.ex = ex; b.ey = ey; b.ez = ez; b.area = a;
        bar_queue.push_back(b);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
            2: return 32'($signed($urandom_range(0, 16)) - 8);
            default: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
        endcase
    endfunction

    // Run one phase of elements and wait until the block is idle again.
    task automatic run_phase();
        feeding = 1'b1;
        wait (bar_queue.size() == 0);
        @(posedge clk);
        feeding = 1'b0;
        wait (expected_geometry.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_modulus(logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        modulus = value;
    endtask

    initial
    begin
        modulus = 32'd65536;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero length, axis-aligned bars, extremes and tiny x.
        add_bar(0, 0, 0, 0, 0, 0, 32'h0001_0000);
        add_bar(32'h1234_5678, 32'h8000_0000, 7, 32'h1234_5678, 32'h8000_0000, 7, '1);
        add_bar(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000);
        add_bar(0, 0, 0, 0, 32'h0001_0000, 0, 32'h0002_0000);
        add_bar(0, 0, 0, 0, 0, 32'hFFFF_0000, 32'h0001_0000);
        add_bar(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1);
        add_bar(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        add_bar(0, 0, 0, 1, 32'h7FFF_FFFF, 0, 32'h0001_0000);
        add_bar(0, 0, 0, 32'hFFFF_FFFF, 0, 32'h8000_0000, 32'h0003_0000);
        add_bar(0, 0, 0, 1, 0, 0, '1);
        add_bar(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        add_bar(5, 5, 5, 4, 6, 4, 32'hFFFF_0000);
        run_phase();

        // Random elements under several modulus settings.
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: write_modulus(32'hFFFF_FFFF);
                1: write_modulus(32'h0000_0000);
                2: write_modulus($urandom);
                default: write_modulus(32'h0001_0000);
            endcase
            for (int i = 0; i < 100; i++)
            begin
                logic [31:0] sx, sy, sz;
                sx = rand_coord(); sy = rand_coord(); sz = rand_coord();
                if ($urandom_range(0, 19) == 0)
                    add_bar(sx, sy, sz, sx, sy, sz, $urandom);
                else
                    add_bar(sx, sy, sz, rand_coord(), rand_coord(), rand_coord(),
                            $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 8)) << 16);
            end
            run_phase();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

`default_nettype wire
